// ----- hw/rtl/ebm_pkg.sv -----
// ----------------------------------------------------------------------------
// ebm_pkg
// Types and codes shared by the embedding-bag inference block.
// ----------------------------------------------------------------------------
package ebm_pkg;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_TOKEN  = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [2:0] REG_EMBED = 3'd0;
  localparam logic [2:0] REG_W1    = 3'd1;
  localparam logic [2:0] REG_B1    = 3'd2;
  localparam logic [2:0] REG_W2    = 3'd3;
  localparam logic [2:0] REG_B2    = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         region;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] weight_value;
    logic [7:0]         token_id;
  } ebm_in_t;

  typedef struct packed {
    logic [5:0]         logit_index;
    logic signed [31:0] logit;
    logic               overflowed;
    logic               last_logit;
  } ebm_out_t;

endpackage

// ----- hw/rtl/ebm_ram.sv -----
// ----------------------------------------------------------------------------
// ebm_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ebm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/embedding_bag_mlp_inference.sv -----
// ----------------------------------------------------------------------------
// embedding_bag_mlp_inference
// Embedding-bag sum, average and two-layer perceptron producing one logit per
// vocabulary entry.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload   | Handshake
//  in_     | input     | ebm_in_t  | in_valid / in_ready
//  out_    | output    | ebm_out_t | out_valid / out_ready
//
// A token makes one pass over the sum memory with a registered read and a
// shared adder. A finish divides each sum element by the token count, then
// runs the hidden and logit passes on a single multiply-accumulate unit; an
// empty finish goes straight to the logit outputs.
// Reset clears control state; the sum memory is cleared by a pass over all
// its entries after reset and after each non-empty finish, during which
// no item is accepted.
// A stalled result holds the logit walk; nothing is lost.
module embedding_bag_mlp_inference
  import ebm_pkg::*;
#(
  parameter int VOCAB_LEN   = 64,
  parameter int EMBED_DIM   = 16,
  parameter int HID_DIM     = 32,
  parameter int TOKEN_LIMIT = 255
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ebm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ebm_out_t out_data
);

  localparam int EW = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
  localparam int HW = (HID_DIM > 1) ? $clog2(HID_DIM) : 1;
  localparam int VW = $clog2(VOCAB_LEN);
  localparam int ED = 1 << EW;
  localparam int HD = 1 << HW;
  localparam int VD = 1 << VW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TOK, S_DIV, S_H_INIT, S_H_MAC, S_H_FIN,
    S_L_INIT, S_L_MAC, S_L_FIN, S_OUT
  } state_t;

  state_t state_r;

  // Memories.
  logic          emb_we, w1_we, b1_we, w2_we, b2_we, sum_we, avg_we, hid_we;
  logic [VW+EW-1:0] emb_wa, emb_ra;
  logic [EW+HW-1:0] w1_wa, w1_ra;
  logic [HW-1:0]    b1_wa, b1_ra, hid_wa, hid_ra;
  logic [HW+VW-1:0] w2_wa, w2_ra;
  logic [VW-1:0]    b2_wa, b2_ra;
  logic [EW-1:0]    sum_wa, sum_ra, avg_wa, avg_ra;
  logic [15:0]      emb_rd, w1_rd, b1_rd, w2_rd, b2_rd, avg_rd, hid_rd;
  logic [15:0]      avg_wd, hid_wd;
  logic [31:0]      sum_wd, sum_rd;

  ebm_ram #(.WIDTH(16), .DEPTH(VD*ED)) u_emb (.clk, .we(emb_we), .waddr(emb_wa),
    .wdata(in_data.weight_value), .raddr(emb_ra), .rdata(emb_rd));
  ebm_ram #(.WIDTH(16), .DEPTH(ED*HD)) u_w1 (.clk, .we(w1_we), .waddr(w1_wa),
    .wdata(in_data.weight_value), .raddr(w1_ra), .rdata(w1_rd));
  ebm_ram #(.WIDTH(16), .DEPTH(HD)) u_b1 (.clk, .we(b1_we), .waddr(b1_wa),
    .wdata(in_data.weight_value), .raddr(b1_ra), .rdata(b1_rd));
  ebm_ram #(.WIDTH(16), .DEPTH(HD*VD)) u_w2 (.clk, .we(w2_we), .waddr(w2_wa),
    .wdata(in_data.weight_value), .raddr(w2_ra), .rdata(w2_rd));
  ebm_ram #(.WIDTH(16), .DEPTH(VD)) u_b2 (.clk, .we(b2_we), .waddr(b2_wa),
    .wdata(in_data.weight_value), .raddr(b2_ra), .rdata(b2_rd));
  ebm_ram #(.WIDTH(32), .DEPTH(ED)) u_sum (.clk, .we(sum_we), .waddr(sum_wa),
    .wdata(sum_wd), .raddr(sum_ra), .rdata(sum_rd));
  ebm_ram #(.WIDTH(16), .DEPTH(ED)) u_avg (.clk, .we(avg_we), .waddr(avg_wa),
    .wdata(avg_wd), .raddr(avg_ra), .rdata(avg_rd));
  ebm_ram #(.WIDTH(16), .DEPTH(HD)) u_hid (.clk, .we(hid_we), .waddr(hid_wa),
    .wdata(hid_wd), .raddr(hid_ra), .rdata(hid_rd));

  // Control and datapath registers.
  logic [7:0]         count_r;
  logic               drop_r;
  logic [VW-1:0]      tok_r;
  logic               tok_ok_r;
  logic [6:0]         i_r;      // element index within a pass
  logic               rv_r;     // read issued last cycle
  logic [EW-1:0]      rj_r;     // index of that read
  logic [6:0]         k_r;      // outer index
  logic signed [47:0] acc_r;
  logic signed [31:0] prod_r;
  logic               pv_r;
  logic               empty_r;
  // Divider.
  logic [31:0]        dmag_r;
  logic [31:0]        quo_r;
  logic [7:0]         rem_r;
  logic               dneg_r;
  logic [5:0]         dstep_r;
  logic               out_valid_r;
  ebm_out_t           out_r;

  logic in_fire;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Weight load decode.
  always_comb begin
    logic mload;
    mload  = in_fire && (in_data.mode == MODE_LOAD);
    emb_we = mload && in_data.region == REG_EMBED &&
             32'(in_data.row_index) < VOCAB_LEN && 32'(in_data.col_index) < EMBED_DIM;
    w1_we  = mload && in_data.region == REG_W1 &&
             32'(in_data.row_index) < EMBED_DIM && 32'(in_data.col_index) < HID_DIM;
    b1_we  = mload && in_data.region == REG_B1 && 32'(in_data.col_index) < HID_DIM;
    w2_we  = mload && in_data.region == REG_W2 &&
             32'(in_data.row_index) < HID_DIM && 32'(in_data.col_index) < VOCAB_LEN;
    b2_we  = mload && in_data.region == REG_B2 && 32'(in_data.col_index) < VOCAB_LEN;
    emb_wa = {in_data.row_index[VW-1:0], in_data.col_index[EW-1:0]};
    w1_wa  = {in_data.row_index[EW-1:0], in_data.col_index[HW-1:0]};
    b1_wa  = in_data.col_index[HW-1:0];
    w2_wa  = {in_data.row_index[HW-1:0], in_data.col_index[VW-1:0]};
    b2_wa  = in_data.col_index[VW-1:0];
  end

  // Read addresses follow the pass indices.
  assign emb_ra = {tok_r, i_r[EW-1:0]};
  assign sum_ra = i_r[EW-1:0];
  assign avg_ra = i_r[EW-1:0];
  assign w1_ra  = {i_r[EW-1:0], k_r[HW-1:0]};
  assign b1_ra  = k_r[HW-1:0];
  assign hid_ra = i_r[HW-1:0];
  assign w2_ra  = {i_r[HW-1:0], k_r[VW-1:0]};
  assign b2_ra  = k_r[VW-1:0];

  // Sum memory write: clear pass, token accumulate, or clear of each element once divided.
  logic [31:0] emb_ext;
  assign emb_ext = tok_ok_r ? 32'(signed'(emb_rd)) : 32'd0;
  always_comb begin
    sum_we = 1'b0;
    sum_wa = i_r[EW-1:0];
    sum_wd = '0;
    case (state_r)
      S_CLEAR: sum_we = 1'b1;
      S_TOK: begin
        sum_we = rv_r;
        sum_wa = rj_r;
        sum_wd = sum_rd + emb_ext;
      end
      S_DIV: begin
        sum_we = (dstep_r == 6'd34);
        sum_wa = rj_r;
      end
      default: ;
    endcase
  end

  // Average store after the divider's sign fix.
  assign avg_we = (state_r == S_DIV) && (dstep_r == 6'd34);
  assign avg_wa = rj_r;
  assign avg_wd = dneg_r ? 16'(-quo_r) : quo_r[15:0];

  // Hidden store with ReLU and saturation.
  logic signed [35:0] hfl;
  assign hfl    = 36'(acc_r >>> 12);
  assign hid_we = (state_r == S_H_FIN);
  assign hid_wa = k_r[HW-1:0];
  assign hid_wd = hfl < 0 ? 16'd0 : (hfl > 36'sd32767 ? 16'h7FFF : hfl[15:0]);

  logic signed [35:0] lfl;
  assign lfl = 36'(acc_r >>> 12);

  logic [32:0] dtry;
  assign dtry = {rem_r, dmag_r[31]} - {25'd0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      i_r         <= '0;
      k_r         <= '0;
      rv_r        <= 1'b0;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      dstep_r     <= '0;
    end else begin
      rj_r <= i_r[EW-1:0];
      // The logit step reloads the output register itself.
      if (out_valid_r && out_ready && state_r != S_L_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // Clear the sum memory after reset and after each non-empty finish.
        S_CLEAR: begin
          if (32'(i_r) == ED - 1) begin
            i_r     <= '0;
            state_r <= S_IDLE;
          end else begin
            i_r <= i_r + 7'd1;
          end
        end
        S_IDLE: begin
          i_r  <= '0;
          rv_r <= 1'b0;
          if (in_fire) begin
            case (in_data.mode)
              MODE_TOKEN: begin
                if (32'(count_r) >= TOKEN_LIMIT) begin
                  drop_r <= 1'b1;
                end else begin
                  count_r  <= count_r + 8'd1;
                  tok_r    <= in_data.token_id[VW-1:0];
                  tok_ok_r <= 32'(in_data.token_id) < VOCAB_LEN;
                  state_r  <= S_TOK;
                end
              end
              MODE_FINISH: begin
                empty_r <= (count_r == 8'd0);
                k_r     <= '0;
                state_r <= (count_r == 8'd0) ? S_L_INIT : S_DIV;
                dstep_r <= '0;
              end
              default: ;
            endcase
          end
        end
        // Read-modify-write of one sum element per cycle.
        S_TOK: begin
          if (32'(i_r) < EMBED_DIM) begin
            i_r  <= i_r + 7'd1;
            rv_r <= 1'b1;
          end else begin
            rv_r <= 1'b0;
            if (!rv_r) state_r <= S_IDLE;
          end
        end
        // Restoring divide of each sum element by the token count.
        S_DIV: begin
          if (dstep_r == 6'd0) begin
            dstep_r <= 6'd1;
          end else if (dstep_r == 6'd1) begin
            dneg_r  <= sum_rd[31];
            dmag_r  <= sum_rd[31] ? -sum_rd : sum_rd;
            rem_r   <= '0;
            quo_r   <= '0;
            dstep_r <= 6'd2;
          end else if (dstep_r < 6'd34) begin
            if (!dtry[32]) rem_r <= dtry[7:0];
            else           rem_r <= {rem_r[6:0], dmag_r[31]};
            quo_r   <= {quo_r[30:0], ~dtry[32]};
            dmag_r  <= {dmag_r[30:0], 1'b0};
            dstep_r <= dstep_r + 6'd1;
          end else begin
            dstep_r <= '0;
            if (32'(i_r) == EMBED_DIM - 1) begin
              i_r     <= '0;
              k_r     <= '0;
              state_r <= S_H_INIT;
            end else begin
              i_r <= i_r + 7'd1;
            end
          end
        end
        // Hidden unit or logit: bias, then a multiply-accumulate over the averages or hidden values.
        S_H_INIT, S_L_INIT: begin
          i_r     <= '0;
          rv_r    <= 1'b0;
          pv_r    <= 1'b0;
          if (dstep_r == 6'd1) begin
            acc_r   <= 48'(signed'(state_r == S_H_INIT ? b1_rd : b2_rd)) <<< 12;
            dstep_r <= '0;
            state_r <= (state_r == S_H_INIT) ? S_H_MAC :
                       (empty_r ? S_L_FIN : S_L_MAC);
          end else begin
            dstep_r <= 6'd1;
          end
        end
        S_H_MAC, S_L_MAC: begin
          if (32'(i_r) < ((state_r == S_H_MAC) ? EMBED_DIM : HID_DIM)) begin
            i_r  <= i_r + 7'd1;
            rv_r <= 1'b1;
          end else begin
            rv_r <= 1'b0;
          end
          pv_r <= rv_r;
          if (rv_r) begin
            prod_r <= (state_r == S_H_MAC) ? signed'(avg_rd) * signed'(w1_rd)
                                          : signed'(hid_rd) * signed'(w2_rd);
          end
          if (pv_r) acc_r <= acc_r + 48'(prod_r);
          if (!rv_r && !pv_r && i_r != 7'd0) begin
            state_r <= (state_r == S_H_MAC) ? S_H_FIN : S_L_FIN;
          end
        end
        S_H_FIN: begin
          if (32'(k_r) == HID_DIM - 1) begin
            k_r <= '0;
            state_r <= S_L_INIT;
          end else begin
            k_r <= k_r + 7'd1;
            state_r <= S_H_INIT;
          end
        end
        // Present one logit once the output register is free.
        S_L_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r       <= 1'b1;
            out_r.logit_index <= 6'(k_r);
            out_r.overflowed  <= drop_r;
            out_r.last_logit  <= (32'(k_r) == VOCAB_LEN - 1);
            if (empty_r) out_r.logit <= '0;
            else if (lfl > 36'sh07FFFFFFF) out_r.logit <= 32'h7FFFFFFF;
            else if (lfl < -36'sh080000000) out_r.logit <= 32'h80000000;
            else out_r.logit <= lfl[31:0];
            if (32'(k_r) == VOCAB_LEN - 1) begin
              state_r <= S_OUT;
            end else begin
              k_r     <= k_r + 7'd1;
              state_r <= S_L_INIT;
            end
          end
        end
        // Wait for the last transfer and reset the sequence.
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            count_r <= '0;
            drop_r  <= 1'b0;
            i_r     <= '0;
            state_r <= empty_r ? S_IDLE : S_CLEAR;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ebm_checker.sv -----
// ----------------------------------------------------------------------------
// ebm_checker
// Port-level checks on the embedding-bag inference block.
// ----------------------------------------------------------------------------
module ebm_checker
  import ebm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input ebm_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input ebm_out_t out_data
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input is not taken while a result is in flight.
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted during logit stream");

  // After the last logit transfer no result follows at once.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_logit |=> !out_valid)
    else $error("result after last logit");

  // No results straight after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind embedding_bag_mlp_inference ebm_checker u_ebm_checker (.*);
